/* sv/polyline_arc_length_lookup_defines.svh */
// Assertion helpers shared by the path lookup block.
`ifndef POLYLINE_ARC_LENGTH_LOOKUP_DEFINES_SVH
`define POLYLINE_ARC_LENGTH_LOOKUP_DEFINES_SVH

// Condition in this cycle implies a condition in the same cycle.
`define PLC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition in this cycle implies a condition in the next cycle.
`define PLC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/plc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package plc_pkg;

   localparam int ARC_MARGIN = 655;
   localparam logic [39:0] TOTAL_MAX = 40'h7F_FFFF_FFFF;
   localparam int SQRT_STEPS = 34;
   localparam int DIV_STEPS = 15;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NOP    = 2'd3
   } plc_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_SQ,
      ST_A_SQRT_GO,
      ST_A_SQRT,
      ST_A_DIV_GO,
      ST_A_DIV,
      ST_A_WR,
      ST_Q_WALK,
      ST_Q_MUL,
      ST_Q_ADD,
      ST_DONE
   } plc_state_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [39:0] arc_length;
   } plc_req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [15:0] tangent_x;
      logic signed [15:0] tangent_y;
      logic signed [15:0] tangent_z;
      logic               found;
      logic               overflow;
   } plc_rsp_type;

endpackage
`default_nettype wire

/* sv/plc_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module plc_sqrt
   import plc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [67:0] radicand,
   output logic             done,
   output logic [33:0]      root
);

   logic [67:0] rad_ff, rad_in;
   logic [35:0] rem_ff, rem_in;
   logic [33:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [35:0] rem_sh, trial;
   logic        ge;

   assign rem_sh = {rem_ff[33:0], rad_ff[67:66]};
   assign trial  = {root_ff, 2'b01};
   assign ge     = rem_sh >= trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'(SQRT_STEPS);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in  = {rad_ff[65:0], 2'b00};
         rem_in  = ge ? rem_sh - trial : rem_sh;
         root_in = {root_ff[32:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

/* sv/plc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module plc_div
   import plc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [46:0] numer,
   input  wire logic [33:0] denom,
   output logic             done,
   output logic [14:0]      quot
);

   logic [33:0] rem_ff, rem_in;
   logic [33:0] den_ff, den_in;
   logic [14:0] low_ff, low_in;
   logic [14:0] q_ff, q_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [34:0] rsh, diff;
   logic        ge;

   assign rsh  = {rem_ff, low_ff[14]};
   assign diff = rsh - {1'b0, den_ff};
   assign ge   = rsh >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         // upper bits are already below the divisor: quotient fits 15 bits
         rem_in = {2'b00, numer[46:15]};
         low_in = numer[14:0];
         den_in = denom;
         q_in   = '0;
         cnt_in = 4'(DIV_STEPS);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[33:0] : rsh[33:0];
         low_in = {low_ff[13:0], 1'b0};
         q_in   = {q_ff[13:0], ge};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
`default_nettype wire

/* sv/polyline_arc_length_lookup.sv */
// Polyline arc-length lookup.
// req_ channel takes one word per command: append a Q15.16 point, clear the
// path, or query the point at a Q23.16 arc length. rsp_ returns exactly one
// word per command, in order.
// Clear, no-op, first append and full-path append finish without arithmetic;
// other appends run three squaring steps, a 34-step bit-serial square root and
// three 15-step divides, one per axis (none for a zero-length segment).
// Queries walk the stored segments one per cycle, then multiply and add on
// each axis. The walk is bound by the single read port of the segment memory.
// One command is in work at a time; req_stall is high while it runs.
// A finished word waits in the output register while rsp_stall is high,
// and the next command is already taken during that wait.
// Reset empties the path and drops any pending word; the point and
// segment memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "polyline_arc_length_lookup_defines.svh"
module polyline_arc_length_lookup
   import plc_pkg::*;
#(
   parameter int MAX_POINTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire plc_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output plc_rsp_type      rsp_data
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);

   logic [2:0][31:0] pt_mem  [MAX_POINTS];
   logic [33:0]      len_mem [MAX_POINTS];
   logic [2:0][15:0] dir_mem [MAX_POINTS];

   logic [2:0][31:0] pt_rd_ff;
   logic [33:0]      len_rd_ff;
   logic [2:0][15:0] dir_rd_ff;

   plc_state_type    state_ff, state_in;
   logic [2:0][31:0] pt_ff, pt_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [39:0]      total_ff, total_in;
   logic [1:0]       axis_ff, axis_in;
   logic [2:0][32:0] d_ff, d_in;
   logic [67:0]      acc_ff, acc_in;
   logic [33:0]      len_ff, len_in;
   logic [2:0][15:0] dir_ff, dir_in;
   logic signed [41:0] remain_ff, remain_in;
   logic [CW-1:0]    issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [2:0][31:0] hit_pt_ff, hit_pt_in;
   logic [2:0][15:0] hit_dir_ff, hit_dir_in;
   logic signed [57:0] prod_ff, prod_in;
   plc_rsp_type      res_ff, res_in;
   plc_rsp_type      rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             pt_we, seg_we;
   logic [AW-1:0]    pt_wa, seg_wa;

   logic             sqrt_start, sqrt_done, div_start, div_done;
   logic [33:0]      sqrt_root;
   logic [14:0]      div_quot;
   logic [46:0]      div_num;

   logic signed [32:0] d_cur;
   logic [32:0]      mag_cur, mag_div;
   logic [65:0]      sq_cur;
   logic [40:0]      tsum;
   logic [CW-1:0]    nseg;
   logic signed [41:0] arc_ext, tot_ext;
   logic signed [57:0] shifted;
   logic signed [45:0] sum_s;
   logic [31:0]      sat_v;
   logic [15:0]      dir_q;
   logic             out_free;
   logic             accept;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign d_cur   = $signed({pt_ff[axis_ff][31], pt_ff[axis_ff]})
                  - $signed({pt_rd_ff[axis_ff][31], pt_rd_ff[axis_ff]});
   assign mag_cur = d_cur[32] ? 33'(-d_cur) : 33'(d_cur);
   assign sq_cur  = {33'b0, mag_cur} * {33'b0, mag_cur};
   assign mag_div = d_ff[axis_ff][32] ? 33'(-$signed(d_ff[axis_ff])) : d_ff[axis_ff];
   assign div_num = {mag_div, 14'b0} + {14'b0, len_ff[33:1]};
   assign dir_q   = d_ff[axis_ff][32] ? 16'(-{1'b0, div_quot}) : {1'b0, div_quot};
   assign tsum    = {1'b0, total_ff} + {7'b0, sqrt_root};
   assign nseg    = (count_ff == '0) ? '0 : count_ff - CW'(1);
   assign arc_ext = {{2{req_data.arc_length[39]}}, req_data.arc_length};
   assign tot_ext = {2'b00, total_ff};
   assign shifted = (prod_ff + 58'sd8192) >>> 14;
   assign sum_s   = $signed(shifted[45:0])
                  + $signed({{14{hit_pt_ff[axis_ff][31]}}, hit_pt_ff[axis_ff]});

   always_comb begin
      if (sum_s > 46'sd2147483647) begin
         sat_v = 32'h7FFF_FFFF;
      end else if (sum_s < -46'sd2147483648) begin
         sat_v = 32'h8000_0000;
      end else begin
         sat_v = sum_s[31:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      pt_in        = pt_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      axis_in      = axis_ff;
      d_in         = d_ff;
      acc_in       = acc_ff;
      len_in       = len_ff;
      dir_in       = dir_ff;
      remain_in    = remain_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      hit_pt_in    = hit_pt_ff;
      hit_dir_in   = hit_dir_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_en        = 1'b0;
      rd_addr      = '0;
      pt_we        = 1'b0;
      pt_wa        = count_ff[AW-1:0];
      seg_we       = 1'b0;
      seg_wa       = nseg[AW-1:0];
      sqrt_start   = 1'b0;
      div_start    = 1'b0;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               res_in   = '0;
               pt_in    = {req_data.point_x, req_data.point_y, req_data.point_z};
               state_in = ST_DONE;
               unique case (plc_op_type'(req_data.opcode))
                  OP_APPEND: begin
                     if (count_ff >= CNT_MAX) begin
                        res_in.overflow = 1'b1;
                     end else begin
                        pt_we = 1'b1;
                        if (count_ff == '0) begin
                           count_in = CW'(1);
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = nseg[AW-1:0];
                           axis_in  = 2'd0;
                           state_in = ST_A_SQ;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  OP_QUERY: begin
                     remain_in = (arc_ext > tot_ext) ? tot_ext - 42'(ARC_MARGIN) : arc_ext;
                     issue_in  = '0;
                     pend_in   = 1'b0;
                     state_in  = ST_Q_WALK;
                  end
                  OP_NOP: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_A_SQ: begin
            d_in[axis_ff] = d_cur;
            acc_in = ((axis_ff == 2'd0) ? 68'd0 : acc_ff) + {2'b00, sq_cur};
            if (axis_ff == 2'd2) begin
               state_in = ST_A_SQRT_GO;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_A_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = ST_A_SQRT;
         end
         ST_A_SQRT: begin
            if (sqrt_done) begin
               len_in   = sqrt_root;
               total_in = (tsum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tsum[39:0];
               dir_in   = '0;
               axis_in  = 2'd0;
               // zero-length segment keeps a zero direction
               state_in = (sqrt_root == '0) ? ST_A_WR : ST_A_DIV_GO;
            end
         end
         ST_A_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_A_DIV;
         end
         ST_A_DIV: begin
            if (div_done) begin
               dir_in[axis_ff] = dir_q;
               if (axis_ff == 2'd2) begin
                  state_in = ST_A_WR;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_A_DIV_GO;
               end
            end
         end
         ST_A_WR: begin
            seg_we   = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = ST_DONE;
         end
         ST_Q_WALK: begin
            // issue the next read while checking the previous one
            if (issue_ff < nseg) begin
               rd_en    = 1'b1;
               rd_addr  = issue_ff[AW-1:0];
               issue_in = issue_ff + CW'(1);
               pend_in  = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (remain_ff <= $signed({8'b0, len_rd_ff})) begin
                  hit_pt_in  = pt_rd_ff;
                  hit_dir_in = dir_rd_ff;
                  axis_in    = 2'd0;
                  pend_in    = 1'b0;
                  state_in   = ST_Q_MUL;
               end else begin
                  remain_in = remain_ff - $signed({8'b0, len_rd_ff});
               end
            end else if (issue_ff >= nseg) begin
               state_in = ST_DONE;
            end
         end
         ST_Q_MUL: begin
            prod_in  = 58'($signed(hit_dir_ff[axis_ff])) * 58'(remain_ff);
            state_in = ST_Q_ADD;
         end
         ST_Q_ADD: begin
            res_in.found = 1'b1;
            // lane 2 holds x, lane 0 holds z
            unique case (axis_ff)
               2'd0: begin
                  res_in.out_z     = sat_v;
                  res_in.tangent_z = hit_dir_ff[0];
               end
               2'd1: begin
                  res_in.out_y     = sat_v;
                  res_in.tangent_y = hit_dir_ff[1];
               end
               default: begin
                  res_in.out_x     = sat_v;
                  res_in.tangent_x = hit_dir_ff[2];
               end
            endcase
            if (axis_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_Q_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (!accept && state_ff == ST_IDLE) begin
         rd_en = 1'b0;
         pt_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_wa] <= {req_data.point_x, req_data.point_y, req_data.point_z};
      end
      if (seg_we) begin
         len_mem[seg_wa] <= len_ff;
         dir_mem[seg_wa] <= dir_ff;
      end
      if (rd_en) begin
         pt_rd_ff  <= pt_mem[rd_addr];
         len_rd_ff <= len_mem[rd_addr];
         dir_rd_ff <= dir_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      pt_ff       <= pt_in;
      axis_ff     <= axis_in;
      d_ff        <= d_in;
      acc_ff      <= acc_in;
      len_ff      <= len_in;
      dir_ff      <= dir_in;
      remain_ff   <= remain_in;
      issue_ff    <= issue_in;
      hit_pt_ff   <= hit_pt_in;
      hit_dir_ff  <= hit_dir_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   plc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   plc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (len_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PLC_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_MAX, "point count past capacity")
   `PLC_ASSERT_NOW(a_total_bound, 1'b1, total_ff <= TOTAL_MAX, "total length past limit")
   `PLC_ASSERT_NOW(a_flags_excl, rsp_valid_ff, !(rsp_data_ff.found && rsp_data_ff.overflow),
      "found and overflow both set")
   `PLC_ASSERT_NEXT(a_done_loads, state_ff == ST_DONE && out_free,
      rsp_valid_ff && state_ff == ST_IDLE, "finished word not loaded")

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_top
   import plc_pkg::*;
();

   localparam int PATH_DEPTH = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   plc_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   plc_rsp_type rsp_data;

   polyline_arc_length_lookup #(.MAX_POINTS(PATH_DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // path model
   logic signed [31:0] path_pt [PATH_DEPTH][3];
   logic [33:0]        path_seg_len [PATH_DEPTH];
   logic signed [15:0] path_seg_dir [PATH_DEPTH][3];
   int                 path_count = 0;
   longint             path_total = 0;

   plc_rsp_type expected_words[$];
   int          error_count = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          hold_request = 0;
   int          idle_cycles = 0;
   int          n_found = 0, n_overflow = 0, n_appends = 0, n_words = 0;
   bit          given_valid = 1'b0;
   plc_rsp_type given_word = '0;

   function automatic logic signed [31:0] saturate32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint scale_by_dir(logic signed [15:0] dir, longint remain);
      longint p;
      p = longint'(dir) * remain + 8192;
      if (p >= 0) return p >>> 14;
      return -(((-p) + 16383) >>> 14);
   endfunction

   task automatic add_point(input plc_req_type r);
      int n;
      longint d [3];
      longint unsigned m, u;
      logic [69:0] sum, c, m70;
      logic [33:0] len;
      n = path_count;
      path_pt[n][0] = r.point_x;
      path_pt[n][1] = r.point_y;
      path_pt[n][2] = r.point_z;
      if (n >= 1) begin
         sum = '0;
         for (int a = 0; a < 3; a++) begin
            d[a] = longint'(path_pt[n][a]) - longint'(path_pt[n-1][a]);
            m70 = (d[a] < 0) ? -d[a] : d[a];
            sum += m70 * m70;
         end
         len = '0;
         for (int b = 33; b >= 0; b--) begin
            c = {36'd0, len} | (70'd1 << b);
            if (c * c <= sum) len = c[33:0];
         end
         path_seg_len[n-1] = len;
         for (int a = 0; a < 3; a++) begin
            path_seg_dir[n-1][a] = '0;
            if (len != 0) begin
               m = (d[a] < 0) ? -d[a] : d[a];
               u = (m * 16384 + len / 2) / len;
               path_seg_dir[n-1][a] = (d[a] < 0) ? -u[15:0] : u[15:0];
            end
         end
         path_total += len;
         if (path_total > 64'sh7F_FFFF_FFFF) path_total = 64'sh7F_FFFF_FFFF;
      end
      path_count = n + 1;
   endtask

   task automatic predict_word(input plc_req_type r, output plc_rsp_type w);
      longint remain, seg;
      int nseg;
      w = '0;
      case (plc_op_type'(r.opcode))
         OP_APPEND: begin
            if (path_count < PATH_DEPTH) add_point(r);
            else w.overflow = 1'b1;
         end
         OP_CLEAR: begin
            path_count = 0;
            path_total = 0;
         end
         OP_QUERY: begin
            remain = longint'(r.arc_length);
            nseg = (path_count >= 1) ? path_count - 1 : 0;
            if (remain > path_total) remain = path_total - ARC_MARGIN;
            for (int i = 0; i < nseg; i++) begin
               seg = path_seg_len[i];
               if (remain <= seg) begin
                  w.out_x = saturate32(path_pt[i][0] + scale_by_dir(path_seg_dir[i][0], remain));
                  w.out_y = saturate32(path_pt[i][1] + scale_by_dir(path_seg_dir[i][1], remain));
                  w.out_z = saturate32(path_pt[i][2] + scale_by_dir(path_seg_dir[i][2], remain));
                  w.tangent_x = path_seg_dir[i][0];
                  w.tangent_y = path_seg_dir[i][1];
                  w.tangent_z = path_seg_dir[i][2];
                  w.found = 1'b1;
                  break;
               end
               remain -= seg;
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on word %0d: %s got %0d expected %0d", n_words, what, got, want);
      error_count++;
   endtask

   task automatic compare_word(input plc_rsp_type got, input plc_rsp_type want);
      if (got.out_x !== want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
      if (got.out_y !== want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
      if (got.out_z !== want.out_z) report_mismatch("out_z", got.out_z, want.out_z);
      if (got.tangent_x !== want.tangent_x)
         report_mismatch("tangent_x", got.tangent_x, want.tangent_x);
      if (got.tangent_y !== want.tangent_y)
         report_mismatch("tangent_y", got.tangent_y, want.tangent_y);
      if (got.tangent_z !== want.tangent_z)
         report_mismatch("tangent_z", got.tangent_z, want.tangent_z);
      if (got.found !== want.found) report_mismatch("found", got.found, want.found);
      if (got.overflow !== want.overflow)
         report_mismatch("overflow", got.overflow, want.overflow);
   endtask

   // both channels are sampled here; outputs still hold pre-edge values
   always @(posedge clock) begin
      plc_rsp_type w;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            idle_cycles = 0;
            predict_word(req_data, w);
            if (given_valid) begin
               if (w !== given_word) begin
                  $display("model disagrees with table row, op %0d", req_data.opcode);
                  error_count++;
               end
               w = given_word;
            end
            expected_words = {expected_words, w};
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (expected_words.size() == 0) begin
               $display("unexpected word %0d on rsp", n_words);
               error_count++;
            end else begin
               w = expected_words.pop_front();
               compare_word(rsp_data, w);
               if (w.found) n_found++;
               if (w.overflow) n_overflow++;
            end
            n_words++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // receiver: random stall, or a long hold when asked
   always @(negedge clock) begin
      int hold;
      if (hold_request > 0) begin
         hold = hold_request;
         hold_request = 0;
         while (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
            @(negedge clock);
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic send_word(input plc_req_type r, input bit has_given = 0,
                            input plc_rsp_type given = '0);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      given_valid = has_given;
      given_word = given;
      do @(posedge clock); while (req_stall);
      if (r.opcode == OP_APPEND) n_appends++;
      @(negedge clock);
   endtask

   function automatic plc_req_type make_word(plc_op_type op, logic [31:0] x = 0,
                                            logic [31:0] y = 0, logic [31:0] z = 0,
                                            logic [39:0] arc = 0);
      plc_req_type r;
      r.opcode = op;
      r.point_x = x;
      r.point_y = y;
      r.point_z = z;
      r.arc_length = arc;
      return r;
   endfunction

   function automatic logic [31:0] rand32();
      return $urandom;
   endfunction

   // random word: path building, mostly near the last point, or a query, now and then a clear or no-op
   task automatic send_random(inout logic signed [31:0] last [3]);
      int pick;
      plc_req_type r;
      longint arc;
      pick = $urandom_range(99);
      if (pick < 48) begin
         r = make_word(OP_APPEND);
         if ($urandom_range(9) == 0) begin
            r.point_x = rand32();
            r.point_y = rand32();
            r.point_z = rand32();
         end else begin
            r.point_x = last[0] + $signed($urandom_range(400000)) - 200000;
            r.point_y = last[1] + $signed($urandom_range(400000)) - 200000;
            r.point_z = last[2] + $signed($urandom_range(4000)) - 2000;
            if ($urandom_range(15) == 0) r.point_y = last[1];
         end
         last[0] = r.point_x;
         last[1] = r.point_y;
         last[2] = r.point_z;
      end else if (pick < 90) begin
         r = make_word(OP_QUERY);
         if ($urandom_range(7) == 0) begin
            r.arc_length = 40'({rand32(), rand32()});
         end else begin
            arc = longint'($urandom_range(100000)) - 2000;
            arc = (path_total > 0) ? (arc * (path_total / 64 + 1)) / 1024 : arc;
            r.arc_length = 40'(arc);
         end
      end else if (pick < 95) begin
         r = make_word(OP_CLEAR, rand32(), rand32(), rand32());
      end else begin
         r = make_word(OP_NOP, rand32(), rand32(), rand32(), 40'({rand32(), rand32()}));
      end
      send_word(r);
   endtask

   typedef struct {
      plc_req_type word;
      bit          has_given;
      plc_rsp_type given;
   } directed_row_type;

   directed_row_type directed_rows[$];
   plc_rsp_type zero_word = '0;
   plc_rsp_type full_word;
   logic signed [31:0] last_point [3];

   task automatic add_row(plc_req_type r, bit has_given = 0, plc_rsp_type given = '0);
      directed_row_type row;
      row.word = r;
      row.has_given = has_given;
      row.given = given;
      directed_rows = {directed_rows, row};
   endtask

   task automatic wait_idle();
      while (expected_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      plc_rsp_type seg_zero;
      full_word = '0;
      full_word.overflow = 1'b1;
      last_point = '{0, 0, 0};
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // query an empty path, single point, extremes, zero-length segment
      add_row(make_word(OP_QUERY, 0, 0, 0, 40'd1000), 1, zero_word);
      add_row(make_word(OP_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1, zero_word);
      add_row(make_word(OP_QUERY, 0, 0, 0, 40'd0), 1, zero_word);
      add_row(make_word(OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      add_row(make_word(OP_QUERY, 0, 0, 0, 40'h7F_FFFF_FFFF));
      add_row(make_word(OP_QUERY, 0, 0, 0, 40'h80_0000_0000));
      add_row(make_word(OP_QUERY, 0, 0, 0, 40'd0));
      add_row(make_word(OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      add_row(make_word(OP_APPEND, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      add_row(make_word(OP_QUERY, 0, 0, 0, 40'h7F_FFFF_FFFF));
      add_row(make_word(OP_QUERY, 0, 0, 0, 40'hFF_FFFF_FFFF));
      add_row(make_word(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        40'hFF_FFFF_FFFF), 1, zero_word);
      add_row(make_word(OP_CLEAR, 32'h5555_5555, 0, 0, 0), 1, zero_word);
      add_row(make_word(OP_QUERY, 0, 0, 0, 40'd500), 1, zero_word);
      add_row(make_word(OP_APPEND, 0, 0, 0), 1, zero_word);
      add_row(make_word(OP_APPEND, 0, 0, 0), 1, zero_word);
      add_row(make_word(OP_APPEND, 32'h0003_0000, 32'h0004_0000, 0));
      add_row(make_word(OP_APPEND, 32'h0003_0000, 32'hFFFC_0000, 32'h0000_0001));
      add_row(make_word(OP_QUERY, 0, 0, 0, 40'h0_0002_8000));
      add_row(make_word(OP_QUERY, 0, 0, 0, 40'h0_0007_0000));
      add_row(make_word(OP_QUERY, 0, 0, 0, 40'h0_0000_0000));
      seg_zero = '0;
      seg_zero.found = 1'b1;
      add_row(make_word(OP_QUERY, 0, 0, 0, 40'hFF_FFFF_0000), 1, seg_zero);
      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].has_given, directed_rows[i].given);
      req_valid <= 1'b0;
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = (phase == 1 || phase == 3) ? 75 : 0;
         receiver_stall_pct = (phase == 2 || phase == 3) ? 75 : 0;
         if (phase == 3) begin
            sender_idle_pct = 7;
            receiver_stall_pct = 7;
         end
         if (phase == 0) begin
            // fill the path past its depth while the receiver holds off
            hold_request = 300;
            send_word(make_word(OP_CLEAR));
            for (int i = 0; i < PATH_DEPTH + 3; i++) begin
               last_point[0] = last_point[0] + $signed($urandom_range(200000));
               last_point[1] = last_point[1] - $signed($urandom_range(200000));
               if (i < PATH_DEPTH) send_word(make_word(OP_APPEND, last_point[0],
                                                       last_point[1], last_point[2]));
               else send_word(make_word(OP_APPEND, rand32(), rand32(), rand32()),
                              1, full_word);
            end
            for (int i = 0; i < 10; i++) send_random(last_point);
            send_word(make_word(OP_CLEAR));
         end
         for (int i = 0; i < 110; i++) send_random(last_point);
         req_valid <= 1'b0;
         wait_idle();
      end

      $display("covered %0d appends, %0d words, %0d queries on a segment, %0d full-path drops",
               n_appends, n_words, n_found, n_overflow);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
